FILE: rtl/mandelbrot_escape_iteration_assert.svh
// Assertion macros used by the top RTL file of the escape-time unit.
`ifndef MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH

// Condition and consequence in the same cycle.
`define MBE_CHECK(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("escape-time unit: assertion failed");

// Consequence in the cycle after the condition.
`define MBE_CHECK_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("escape-time unit: assertion failed");

`endif

FILE: rtl/mbe_pkg.sv
package mbe_pkg;

    // Input coordinate width, signed 8.8.
    localparam int C_W      = 16;
    // Running z width. While a point has not escaped, |z| stays below 2^16.
    localparam int Z_W      = 17;
    localparam int PROD_W   = 2 * Z_W;
    // Count width covers iteration limits up to 127.
    localparam int CNT_W    = 7;
    localparam int ITER_W   = 5;
    localparam int GLYPH_W  = 7;
    localparam int MAX_ITER_DEFAULT = 20;

    // Escape threshold, 4.0 in 8.8.
    localparam logic signed [PROD_W-1:0] ESC_LIM = PROD_W'(4 << 8);

    localparam logic [GLYPH_W-1:0] GLYPH_AT = 7'h40;
    localparam int RAMP_N = 10;
    localparam logic [GLYPH_W-1:0] RAMP [0:RAMP_N-1] = '{
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
    };

    typedef struct packed {
        logic signed [Z_W-1:0] zr;
        logic signed [Z_W-1:0] zi;
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
        logic [CNT_W-1:0]      cnt;
        logic                  done;
    } t_point;

endpackage

FILE: rtl/mbe_iter.sv
module mbe_iter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  mbe_pkg::t_point i_pt,
    output logic           o_valid,
    output mbe_pkg::t_point o_pt
);
    import mbe_pkg::*;

    // Stage A: the three products of one iteration.
    logic                      r_a_valid;
    logic signed [PROD_W-1:0]  r_rr;
    logic signed [PROD_W-1:0]  r_ii;
    logic signed [PROD_W-1:0]  r_ri;
    t_point                    r_a_pt;

    logic signed [PROD_W-1:0]  n_rr;
    logic signed [PROD_W-1:0]  n_ii;
    logic signed [PROD_W-1:0]  n_ri;

    assign n_rr = PROD_W'(i_pt.zr) * PROD_W'(i_pt.zr);
    assign n_ii = PROD_W'(i_pt.zi) * PROD_W'(i_pt.zi);
    assign n_ri = PROD_W'(i_pt.zr) * PROD_W'(i_pt.zi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rr   <= n_rr;
            r_ii   <= n_ii;
            r_ri   <= n_ri;
            r_a_pt <= i_pt;
        end
    end

    // Stage B: escape test and the update of z.
    logic signed [PROD_W-1:0]  w_zr2;
    logic signed [PROD_W-1:0]  w_zi2;
    logic signed [PROD_W-1:0]  w_mag;
    logic signed [PROD_W-1:0]  w_zr_full;
    logic signed [PROD_W-1:0]  w_zi_full;
    logic                      w_esc;
    logic                      r_b_valid;
    t_point                    r_b_pt;
    t_point                    n_b_pt;

    always_comb begin
        w_zr2     = r_rr >>> 8;
        w_zi2     = r_ii >>> 8;
        w_mag     = w_zr2 + w_zi2;
        w_esc     = w_mag > ESC_LIM;
        w_zr_full = w_zr2 - w_zi2 + PROD_W'(r_a_pt.cr);
        w_zi_full = (r_ri >>> 7) + PROD_W'(r_a_pt.ci);

        n_b_pt      = r_a_pt;
        n_b_pt.zr   = Z_W'(w_zr_full);
        n_b_pt.zi   = Z_W'(w_zi_full);
        n_b_pt.done = r_a_pt.done | w_esc;
        if (!r_a_pt.done && !w_esc) begin
            n_b_pt.cnt = r_a_pt.cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_pt <= n_b_pt;
        end
    end

    assign o_valid = r_b_valid;
    assign o_pt    = r_b_pt;

endmodule

FILE: rtl/mandelbrot_escape_iteration.sv
// Channel  Direction  Handshake                  Payload
// input    in         i_in_valid / o_in_ready    i_c_real, i_c_imag
// output   out        o_out_valid / i_out_ready  o_iterations, o_in_set, o_glyph
//
// One item enters per cycle while the output is not stalled. There are 2*MAX_ITER+1
// register stages: one multiply stage and one update stage per unrolled iteration,
// plus the output register. The first stage captures the item at the accepting
// edge; its result then passes through every stage in order to the output register.
// Reset (synchronous, active low) clears every valid bit; payload is not reset.
// The whole pipeline advances together; it holds while the output register
// carries a result that is not taken, and nothing is lost or repeated.
module mandelbrot_escape_iteration #(
    parameter int MAX_ITER = mbe_pkg::MAX_ITER_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [mbe_pkg::C_W-1:0] i_c_real,
    input  logic signed [mbe_pkg::C_W-1:0] i_c_imag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mbe_pkg::ITER_W-1:0]   o_iterations,
    output logic                         o_in_set,
    output logic [mbe_pkg::GLYPH_W-1:0]  o_glyph
);
    import mbe_pkg::*;

`include "mandelbrot_escape_iteration_assert.svh"

    localparam int TBL_N = 2 ** CNT_W;

    // The pipeline moves whenever the output register is empty or being drained.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Point chain: entry k feeds iteration k; entry MAX_ITER is the final state.
    t_point w_pt    [0:MAX_ITER];
    logic   w_valid [0:MAX_ITER];

    // A new point starts at z = 0 with no iterations counted.
    t_point w_in_pt;

    always_comb begin
        w_in_pt    = '0;
        w_in_pt.cr = i_c_real;
        w_in_pt.ci = i_c_imag;
    end

    assign w_pt[0]    = w_in_pt;
    assign w_valid[0] = i_in_valid;

    for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
        mbe_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_pt    (w_pt[k]),
            .o_valid (w_valid[k+1]),
            .o_pt    (w_pt[k+1])
        );
    end

    // Glyph lookup by final count. The ramp index (count*9)/MAX_ITER is fixed at
    // elaboration for each count below the limit; counts at or past the limit give '@'.
    logic [GLYPH_W-1:0] w_glyph_tbl [0:TBL_N-1];

    for (genvar k = 0; k < TBL_N; k++) begin : g_glyph
        localparam int IDX = (k >= MAX_ITER) ? (RAMP_N - 1) : ((k * 9) / MAX_ITER);
        assign w_glyph_tbl[k] = RAMP[IDX];
    end

    // Output register.
    logic               r_out_valid;
    logic [ITER_W-1:0]  r_iterations;
    logic               r_in_set;
    logic [GLYPH_W-1:0] r_glyph;
    logic               n_in_set;
    logic [GLYPH_W-1:0] n_glyph;

    always_comb begin
        // A point that never escaped ran all MAX_ITER iterations.
        n_in_set = !w_pt[MAX_ITER].done;
        n_glyph  = n_in_set ? GLYPH_AT : w_glyph_tbl[w_pt[MAX_ITER].cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[MAX_ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_iterations <= w_pt[MAX_ITER].cnt[ITER_W-1:0];
            r_in_set     <= n_in_set;
            r_glyph      <= n_glyph;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_iterations = r_iterations;
    assign o_in_set     = r_in_set;
    assign o_glyph      = r_glyph;

    `MBE_CHECK(a_inset_glyph, i_clk, i_rst_n, o_out_valid && o_in_set, o_glyph == GLYPH_AT)
    `MBE_CHECK(a_inset_count, i_clk, i_rst_n, o_out_valid && o_in_set, o_iterations == ITER_W'(MAX_ITER))
    `MBE_CHECK(a_escape_glyph, i_clk, i_rst_n, o_out_valid && !o_in_set, o_glyph != GLYPH_AT)
    `MBE_CHECK_NEXT(a_last_to_out, i_clk, i_rst_n, w_en && w_valid[MAX_ITER], o_out_valid)

endmodule
